### rtl/gtp_pkg.sv
`timescale 1ns / 1ps

package gtp_pkg;

  localparam int unsigned CordW = 48;
  localparam int unsigned ZW    = 26;
  localparam int unsigned SqW   = 42;
  localparam int unsigned DistW = 21;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic        [15:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic        [1:0]  mode;
  } out_t;

  typedef enum logic [1:0] {
    MODE_DRIVE   = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_REACHED = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_GOAL_HEADING = 3'd2,
    REG_POS_TOL      = 3'd3,
    REG_HEAD_TOL     = 3'd4,
    REG_DIST_GAIN    = 3'd5,
    REG_TURN_GAIN    = 3'd6,
    REG_SPEED_LIMITS = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_LAUNCH,
    ST_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } state_e;

  localparam logic TAG_YAW     = 1'b0;
  localparam logic TAG_BEARING = 1'b1;

  localparam logic signed [ZW-1:0] HalfTurn = 26'sd8388608;

  // Vector and angle handed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic                    tag;
    logic                    zero;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
  } cell_t;

  // Arctangent of 2^-i in units of 2^-24 turn
  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:    a = 26'sd2097152;
      5'd1:    a = 26'sd1238021;
      5'd2:    a = 26'sd654136;
      5'd3:    a = 26'sd332050;
      5'd4:    a = 26'sd166669;
      5'd5:    a = 26'sd83416;
      5'd6:    a = 26'sd41718;
      5'd7:    a = 26'sd20860;
      5'd8:    a = 26'sd10430;
      5'd9:    a = 26'sd5215;
      5'd10:   a = 26'sd2608;
      5'd11:   a = 26'sd1304;
      5'd12:   a = 26'sd652;
      5'd13:   a = 26'sd326;
      5'd14:   a = 26'sd163;
      5'd15:   a = 26'sd81;
      5'd16:   a = 26'sd41;
      5'd17:   a = 26'sd20;
      5'd18:   a = 26'sd10;
      5'd19:   a = 26'sd5;
      5'd20:   a = 26'sd3;
      5'd21:   a = 26'sd1;
      5'd22:   a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

### rtl/gtp_cordic_cell.sv
`timescale 1ns / 1ps

module gtp_cordic_cell import gtp_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t cell_d, cell_q;
  logic signed [CordW-1:0] xs, ys;

  always_comb begin
    xs     = cell_i.x >>> SHIFT;
    ys     = cell_i.y >>> SHIFT;
    cell_d = cell_i;
    // rotate towards the x axis
    if (cell_i.y >= 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + atan_at(5'(SHIFT));
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - atan_at(5'(SHIFT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/gtp_cordic_chain.sv
`timescale 1ns / 1ps

module gtp_cordic_chain import gtp_pkg::*; #(
  parameter int unsigned STEPS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t head_i,
  output cell_t tail_o
);

  cell_t link [STEPS+1];

  assign link[0] = head_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    gtp_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  assign tail_o = link[STEPS];

endmodule

### rtl/gtp_isqrt.sv
`timescale 1ns / 1ps

module gtp_isqrt import gtp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   radicand_i,
  output logic             busy_o,
  output logic [DistW-1:0] root_o
);

  localparam logic [SqW-1:0] StartBit = SqW'(1) << (SqW - 2);

  logic [SqW-1:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d, trial;
  logic           busy_q, busy_d;

  always_comb begin
    trial  = root_q + bit_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = radicand_i;
      root_d = '0;
      bit_d  = StartBit;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one result bit per cycle
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d  = bit_q >> 2;
      busy_d = (bit_q != SqW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q[DistW-1:0];

endmodule

### rtl/go_to_pose_controller.sv
`timescale 1ns / 1ps

// Go-to-pose controller: one velocity command for each pose sample.
// Input channel: in_valid_i / in_stall_o / in_data_i (position and
// orientation quaternion). Output channel: out_valid_o / out_stall_i /
// out_data_o (forward speed, turn rate, mode). A transfer happens at a
// clock edge with valid high and stall low.
// One sample is worked on at a time; in_stall_o is high from the transfer
// until the command is placed in the output register. The distance root
// is worked out one bit a cycle. Yaw and goal bearing run through the
// same chain of CORDIC_STEPS cells, the bearing in the cycle after yaw.
// The output register holds one command; while the receiver stalls the
// block still takes and works the next sample, and holds it finished
// until the register frees.
// Reset loads the default goal, tolerances, gains and limits and clears the
// reached flag. Once reached, every command is zero with mode reached until
// the next reset. Registers are written by cfg_we_i, cfg_idx_i and cfg_data_i
// only while no sample is in flight; the user must keep to it, unenforced.
module go_to_pose_controller import gtp_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  localparam logic [16:0] EighthTurn = 17'd8192;
  localparam logic signed [52:0] TwoPiQ16 = 53'sd411775;
  localparam logic signed [52:0] TurnRound = 53'sd2147483648;
  localparam logic [15:0] RecipFive = 16'd52429;

  // configuration
  logic signed [19:0] goal_x_q, goal_y_q;
  logic [15:0] goal_heading_q;
  logic [18:0] pos_tol_q;
  logic [14:0] head_tol_q;
  logic [15:0] dist_gain_q, turn_gain_q;
  logic [30:0] speed_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q       <= -20'sd1086;
      goal_y_q       <= -20'sd530;
      goal_heading_q <= 16'd16384;
      pos_tol_q      <= 19'd410;
      head_tol_q     <= 15'd1456;
      dist_gain_q    <= 16'd3686;
      turn_gain_q    <= 16'd6554;
      speed_lim_q    <= 31'd214763110;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_GOAL_X:       goal_x_q       <= cfg_data_i[19:0];
        REG_GOAL_Y:       goal_y_q       <= cfg_data_i[19:0];
        REG_GOAL_HEADING: goal_heading_q <= cfg_data_i[15:0];
        REG_POS_TOL:      pos_tol_q      <= cfg_data_i[18:0];
        REG_HEAD_TOL:     head_tol_q     <= cfg_data_i[14:0];
        REG_DIST_GAIN:    dist_gain_q    <= cfg_data_i[15:0];
        REG_TURN_GAIN:    turn_gain_q    <= cfg_data_i[15:0];
        REG_SPEED_LIMITS: speed_lim_q    <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // control
  state_e state_q, state_d;
  logic   reached_q, reached_d;
  logic   yaw_ok_q, brg_ok_q;
  logic   out_valid_q, out_load;
  out_t   out_q, out_d;
  logic   in_xfer, sq_busy;

  // datapath
  in_t                pose_q;
  logic signed [20:0] dx_q, dy_q;
  logic signed [31:0] p_wz_q, p_xy_q, p_yy_q, p_zz_q;
  logic [SqW-1:0]     dx2_q, dy2_q;
  logic [15:0]        yaw_q, brg_q;
  logic [DistW-1:0]   root;
  logic               near_q, aligned_q, steep_q;
  logic signed [32:0] t1_q;
  logic [36:0]        fp_q;
  logic signed [52:0] t2_q;
  logic [15:0]        v_q;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // chain feed
  cell_t head, tail;
  logic signed [33:0] sy, cy;
  logic signed [CordW-1:0] vx, vy;
  logic signed [ZW-1:0] z_rnd;

  always_comb begin
    sy = (34'(p_wz_q) + 34'(p_xy_q)) <<< 1;
    cy = 34'sd268435456 - ((34'(p_yy_q) + 34'(p_zz_q)) <<< 1);
    if (state_q == ST_LAUNCH) begin
      vx = CordW'(dx_q) <<< 24;
      vy = CordW'(dy_q) <<< 24;
    end else begin
      vx = CordW'(cy) <<< 12;
      vy = CordW'(sy) <<< 12;
    end
    head       = '0;
    head.valid = (state_q == ST_SUM) || (state_q == ST_LAUNCH);
    head.tag   = (state_q == ST_LAUNCH) ? TAG_BEARING : TAG_YAW;
    head.zero  = (vx == '0) && (vy == '0);
    // fold the left half plane over
    if (vx < 0) begin
      head.x = -vx;
      head.y = -vy;
      head.z = HalfTurn;
    end else begin
      head.x = vx;
      head.y = vy;
      head.z = '0;
    end
  end

  gtp_cordic_chain #(
    .STEPS(CORDIC_STEPS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .tail_o (tail)
  );

  gtp_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_SUM),
    .radicand_i (dx2_q + dy2_q),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  assign z_rnd = tail.z + 26'sd128;

  // error and products
  logic signed [15:0] e_goal, e_brg, err;
  logic [16:0]        ae;
  logic signed [16:0] tg_s;
  logic [24:0]        fr;

  always_comb begin
    e_goal = signed'(goal_heading_q - yaw_q);
    e_brg  = signed'(brg_q - yaw_q);
    err    = (root < DistW'(pos_tol_q)) ? e_goal : e_brg;
    ae     = err[15] ? 17'(-(17'(err))) : 17'(err);
    tg_s   = signed'({1'b0, turn_gain_q});
    fr     = 25'((fp_q + 37'd2048) >> 12);
  end

  // final command
  logic signed [52:0] t2_sum;
  logic signed [20:0] tr, lim_s;
  logic signed [15:0] turn;
  logic [33:0]        v5_prod;
  logic [15:0]        fwd;

  always_comb begin
    t2_sum  = t2_q + TurnRound;
    tr      = t2_sum[52:32];
    lim_s   = signed'({6'b0, speed_lim_q[30:16]});
    if (tr > lim_s) begin
      turn = 16'(lim_s);
    end else if (tr < -lim_s) begin
      turn = 16'(-lim_s);
    end else begin
      turn = 16'(tr);
    end
    v5_prod = (34'(v_q) + 34'd2) * 34'(RecipFive);
    fwd     = steep_q ? v5_prod[33:18] : v_q;
  end

  always_comb begin
    out_d     = '0;
    reached_d = reached_q;
    out_d.mode = MODE_REACHED;
    priority if (reached_q || (near_q && aligned_q)) begin
      reached_d = 1'b1;
    end else if (near_q) begin
      out_d.turn_rate = turn;
      out_d.mode      = MODE_TURN;
    end else begin
      out_d.forward_speed = fwd;
      out_d.turn_rate     = turn;
      out_d.mode          = MODE_DRIVE;
    end
  end

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_PROD;
      ST_PROD:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_WAIT;
      ST_WAIT:   if (yaw_ok_q && brg_ok_q && !sq_busy) state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_FIN;
      ST_FIN:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reached_q   <= 1'b0;
      yaw_ok_q    <= 1'b0;
      brg_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        yaw_ok_q <= 1'b0;
        brg_ok_q <= 1'b0;
      end else if (tail.valid) begin
        if (tail.tag == TAG_BEARING) brg_ok_q <= 1'b1;
        else yaw_ok_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        reached_q   <= reached_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pose_q <= in_data_i;
      dx_q   <= 21'(goal_x_q) - 21'(in_data_i.pos_x);
      dy_q   <= 21'(goal_y_q) - 21'(in_data_i.pos_y);
    end
    if (state_q == ST_PROD) begin
      p_wz_q <= 32'(pose_q.quat_w) * 32'(pose_q.quat_z);
      p_xy_q <= 32'(pose_q.quat_x) * 32'(pose_q.quat_y);
      p_yy_q <= 32'(pose_q.quat_y) * 32'(pose_q.quat_y);
      p_zz_q <= 32'(pose_q.quat_z) * 32'(pose_q.quat_z);
      dx2_q  <= SqW'(42'(dx_q) * 42'(dx_q));
      dy2_q  <= SqW'(42'(dy_q) * 42'(dy_q));
    end
    if (tail.valid) begin
      if (tail.tag == TAG_BEARING) brg_q <= tail.zero ? 16'd0 : z_rnd[23:8];
      else yaw_q <= tail.zero ? 16'd0 : z_rnd[23:8];
    end
    if (state_q == ST_MUL1) begin
      near_q    <= (root < DistW'(pos_tol_q));
      aligned_q <= (ae < 17'(head_tol_q));
      steep_q   <= (ae > EighthTurn);
      t1_q      <= 33'(tg_s) * 33'(err);
      fp_q      <= 37'(dist_gain_q) * 37'(root);
    end
    if (state_q == ST_MUL2) begin
      t2_q <= 53'(t1_q) * TwoPiQ16;
      v_q  <= (fr > 25'(speed_lim_q[15:0])) ? speed_lim_q[15:0] : fr[15:0];
    end
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/gtp_checker.sv
`timescale 1ns / 1ps

module gtp_checker import gtp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled command holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // one sample at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.mode != 2'd3)
    else $error("bad mode");

  a_reached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == MODE_REACHED |->
      out_data_o.forward_speed == '0 && out_data_o.turn_rate == '0)
    else $error("reached command not zero");

  a_turn_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == MODE_TURN |-> out_data_o.forward_speed == '0)
    else $error("forward speed while turning in place");

endmodule

bind go_to_pose_controller gtp_checker u_gtp_checker (.*);

### tb/sv/pose_cmd_checker.sv
`timescale 1ns / 1ps

module pose_cmd_checker import gtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  localparam int Steps = 16;

  // arctan(2^-i) in 2^-24 turn
  localparam longint ArcTab [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  localparam logic [30:0] RegMask [8] = '{
    31'hFFFFF, 31'hFFFFF, 31'hFFFF, 31'h7FFFF, 31'h7FFF, 31'hFFFF, 31'hFFFF, 31'h7FFFFFFF
  };

  logic [30:0] regs [8];
  logic        reached;
  out_t        cmd_q [$];

  function automatic logic [15:0] bin_angle(input longint xi, input longint yi);
    longint x, y, z, xs, ys;
    logic [63:0] r;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd8388608;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ArcTab[i];
      end else begin
        x -= ys; y += xs; z -= ArcTab[i];
      end
    end
    r = z + 128;
    return r[23:8];
  endfunction

  function automatic longint unsigned root(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] turn_for(input logic signed [15:0] err);
    longint pr, lim;
    pr = longint'(regs[REG_TURN_GAIN][15:0]) * longint'(err) * 64'sd411775;
    pr = (pr + 64'sd2147483648) >>> 32;
    lim = longint'(regs[REG_SPEED_LIMITS][30:16]);
    if (pr > lim) pr = lim;
    if (pr < -lim) pr = -lim;
    return pr[15:0];
  endfunction

  function automatic out_t plan_command(input in_t p);
    out_t c;
    longint dx, dy, sy, cy;
    longint unsigned goal_dist, v, gain;
    logic [15:0] yaw, bearing;
    logic signed [15:0] err;
    int mag;
    c = '0;
    c.mode = MODE_REACHED;
    if (!reached) begin
      dx = longint'($signed(regs[REG_GOAL_X][19:0])) - longint'(p.pos_x);
      dy = longint'($signed(regs[REG_GOAL_Y][19:0])) - longint'(p.pos_y);
      goal_dist = root(dx * dx + dy * dy);
      sy = 2 * (longint'(p.quat_w) * longint'(p.quat_z)
              + longint'(p.quat_x) * longint'(p.quat_y));
      cy = 64'sd268435456 - 2 * (longint'(p.quat_y) * longint'(p.quat_y)
                                 + longint'(p.quat_z) * longint'(p.quat_z));
      yaw = bin_angle(cy * 4096, sy * 4096);
      if (goal_dist < regs[REG_POS_TOL][18:0]) begin
        err = regs[REG_GOAL_HEADING][15:0] - yaw;
        mag = (err < 0) ? -int'(err) : int'(err);
        if (mag < int'(regs[REG_HEAD_TOL][14:0])) begin
          reached = 1'b1;
        end else begin
          c.turn_rate = turn_for(err);
          c.mode = MODE_TURN;
        end
      end else begin
        bearing = bin_angle(dx * 16777216, dy * 16777216);
        err = bearing - yaw;
        mag = (err < 0) ? -int'(err) : int'(err);
        gain = 64'(regs[REG_DIST_GAIN][15:0]);
        v = (gain * goal_dist + 2048) >> 12;
        if (v > 64'(regs[REG_SPEED_LIMITS][15:0])) v = 64'(regs[REG_SPEED_LIMITS][15:0]);
        if (mag > 8192) v = (v + 2) / 5;
        c.forward_speed = v[15:0];
        c.turn_rate = turn_for(err);
        c.mode = MODE_DRIVE;
      end
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      regs[0] = 31'(20'hFFBC2);
      regs[1] = 31'(20'hFFDEE);
      regs[2] = 31'd16384;
      regs[3] = 31'd410;
      regs[4] = 31'd1456;
      regs[5] = 31'd3686;
      regs[6] = 31'd6554;
      regs[7] = 31'd214763110;
      reached = 1'b0;
      cmd_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) regs[cfg_idx_i] = cfg_data_i & RegMask[cfg_idx_i];
      if (out_valid_i && !out_stall_i) begin
        if (cmd_q.size() == 0) begin
          errors_o++;
          $display("%0t: command with none expected, got %p", $time, out_data_i);
        end else begin
          want = cmd_q.pop_front();
          if (out_data_i.forward_speed !== want.forward_speed) begin
            errors_o++;
            $display("%0t: forward_speed expected %0d got %0d", $time,
                     want.forward_speed, out_data_i.forward_speed);
          end
          if (out_data_i.turn_rate !== want.turn_rate) begin
            errors_o++;
            $display("%0t: turn_rate expected %0d got %0d", $time,
                     want.turn_rate, out_data_i.turn_rate);
          end
          if (out_data_i.mode !== want.mode) begin
            errors_o++;
            $display("%0t: mode expected %0d got %0d", $time, want.mode, out_data_i.mode);
          end
        end
      end
      if (in_valid_i && !in_stall_i) cmd_q.push_back(plan_command(in_data_i));
    end
    pending_o = cmd_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gtp_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int Settle     = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  in_t         in_data = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_t        out_data_o;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [30:0] cfg_data = '0;

  int pending, errors, idle_cycles, sent, settings, stall_left;
  logic quiet = 1'b0;

  // local copy of the goal, used only to aim stimulus
  logic signed [19:0] goal_x, goal_y;
  logic signed [15:0] goal_hd;
  int unsigned        pos_tol;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  go_to_pose_controller uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o, .in_data_i(in_data),
    .out_valid_o, .out_stall_i(out_stall), .out_data_o,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  pose_cmd_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall_o), .in_data_i(in_data),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall), .out_data_i(out_data_o),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  // receiver stalls in short bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchLimit) begin
        $display("timeout: no transfer for %0d cycles", WatchLimit);
        $display("testbench: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  function automatic in_t raw_pose(input int px, input int py,
                                   input int qx, input int qy, input int qz, input int qw);
    in_t p;
    p.pos_x = px[19:0];
    p.pos_y = py[19:0];
    p.quat_x = qx[15:0];
    p.quat_y = qy[15:0];
    p.quat_z = qz[15:0];
    p.quat_w = qw[15:0];
    return p;
  endfunction

  // near-unit quaternion for a yaw given as binary angle
  function automatic in_t face(input in_t p, input logic signed [15:0] ang);
    real th;
    th = $itor(ang) * 3.14159265358979 / 65536.0;
    p.quat_x = $urandom_range(0, 3) == 0 ? 16'($signed($urandom_range(0, 200)) - 100) : '0;
    p.quat_y = $urandom_range(0, 3) == 0 ? 16'($signed($urandom_range(0, 200)) - 100) : '0;
    p.quat_z = 16'($rtoi(16384.0 * $sin(th)));
    p.quat_w = 16'($rtoi(16384.0 * $cos(th)));
    return p;
  endfunction

  function automatic in_t random_pose();
    in_t p;
    int kind, span;
    int extremes [5];
    extremes = '{-32768, -16384, 0, 16384, 32767};
    kind = $urandom_range(0, 9);
    p.pos_x = 20'($urandom);
    p.pos_y = 20'($urandom);
    p.quat_x = 16'($urandom);
    p.quat_y = 16'($urandom);
    p.quat_z = 16'($urandom);
    p.quat_w = 16'($urandom);
    if (kind >= 2 && kind <= 5) begin
      span = (pos_tol > 4096 ? 4096 : pos_tol) * 2 + 64;
      p.pos_x = goal_x + 20'($urandom_range(0, 2 * span) - span);
      p.pos_y = goal_y + 20'($urandom_range(0, 2 * span) - span);
      if (kind == 5) p = face(p, goal_hd + 16'($urandom_range(0, 4000) - 2000));
      else p = face(p, 16'($urandom));
    end else if (kind >= 6 && kind <= 8) begin
      if (kind == 8) begin
        p.pos_x = goal_x + 20'($urandom_range(0, 60000) - 30000);
        p.pos_y = goal_y + 20'($urandom_range(0, 60000) - 30000);
      end
      p = face(p, 16'($urandom));
    end else if (kind == 9) begin
      p.quat_x = 16'(extremes[$urandom_range(0, 4)]);
      p.quat_y = 16'(extremes[$urandom_range(0, 4)]);
      p.quat_z = 16'(extremes[$urandom_range(0, 4)]);
      p.quat_w = 16'(extremes[$urandom_range(0, 4)]);
    end
    return p;
  endfunction

  task automatic send_pose(input in_t p);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [19:0] gx, input logic [19:0] gy,
                              input logic [15:0] gh, input logic [18:0] ptol,
                              input logic [14:0] htol, input logic [15:0] dgain,
                              input logic [15:0] tgain, input logic [30:0] limits);
    write_reg(REG_GOAL_X, 31'(gx));
    write_reg(REG_GOAL_Y, 31'(gy));
    write_reg(REG_GOAL_HEADING, 31'(gh));
    write_reg(REG_POS_TOL, 31'(ptol));
    write_reg(REG_HEAD_TOL, 31'(htol));
    write_reg(REG_DIST_GAIN, 31'(dgain));
    write_reg(REG_TURN_GAIN, 31'(tgain));
    write_reg(REG_SPEED_LIMITS, limits);
    cfg_we <= 1'b0;
    goal_x = gx;
    goal_y = gy;
    goal_hd = gh;
    pos_tol = ptol;
    settings++;
  endtask

  initial begin
    sent = 0;
    settings = 1;
    goal_x = -20'sd1086;
    goal_y = -20'sd530;
    goal_hd = 16'sd16384;
    pos_tol = 410;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default goal: field extremes, odd quaternions, turning in place without alignment
    send_pose(raw_pose(524287, 524287, 0, 0, 0, 16384));
    send_pose(raw_pose(-524288, -524288, 0, 0, 16384, 0));
    send_pose(raw_pose(524287, -524288, -16384, -16384, -16384, -16384));
    send_pose(raw_pose(-524288, 524287, 16384, 16384, 16384, 16384));
    send_pose(raw_pose(0, 0, 32767, 32767, 32767, 32767));
    send_pose(raw_pose(0, 0, -32768, -32768, -32768, -32768));
    send_pose(raw_pose(5000, 5000, 0, 8192, 8192, 0));
    send_pose(raw_pose(3000, -9000, 100, 200, 300, 400));
    send_pose(raw_pose(-41086, -530, 0, 0, 0, 16384));
    send_pose(raw_pose(-41086, -530, 0, 0, 16384, 0));
    send_pose(raw_pose(-1086, -530, 0, 0, 0, 16384));
    send_pose(raw_pose(-1086, -530, 0, 0, -11585, 11585));
    send_pose(raw_pose(-1086, -530, 0, 0, 16384, 0));
    send_pose(raw_pose(-1000, -500, 0, 0, 16384, -1));
    drain();

    apply_config(20'h80000, 20'h7FFFF, 16'h8000, 19'h7FFFF, 15'd0,
                 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF);
    repeat (350) send_pose(random_pose());
    drain();

    // zero tolerance is never met, so a pose on the goal drives with no bearing
    apply_config(20'h7FFFF, 20'h80000, 16'h7FFF, 19'd0, 15'h7FFF,
                 16'd0, 16'd0, 31'd0);
    send_pose(raw_pose(524287, -524288, 0, 0, 0, 16384));
    send_pose(raw_pose(524287, -524288, 0, 8192, 8192, 0));
    repeat (350) send_pose(random_pose());
    drain();

    apply_config(20'($urandom_range(0, 131072) - 65536), 20'($urandom_range(0, 131072) - 65536),
                 16'($urandom), 19'd2000, 15'd0, 16'($urandom), 16'($urandom),
                 31'($urandom));
    repeat (350) send_pose(random_pose());
    drain();

    apply_config(20'd1200, -20'sd800, 16'd8000, 19'd600, 15'd1500,
                 16'd3686, 16'd6554, {15'd8192, 16'd6000});
    for (int i = 0; i < 450; i++) begin
      if (i == 250) quiet = 1'b1;
      send_pose(random_pose());
    end
    drain();

    $display("sent %0d pose samples across %0d register settings,", sent, settings);
    $display("driving, turning in place and the sticky stop included");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/gtp_pkg.sv
rtl/gtp_cordic_cell.sv
rtl/gtp_cordic_chain.sv
rtl/gtp_isqrt.sv
rtl/go_to_pose_controller.sv
rtl/gtp_checker.sv
tb/sv/pose_cmd_checker.sv
tb/sv/testbench.sv
